// File: sv/chip8_instruction_core_defines.svh
// Assertion macros included by the port-level checker of the instruction core.
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define C8_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define C8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/c8_pkg.sv
// Shared constants, types and the hex font of the instruction core.
`timescale 1ns / 1ps
package c8_pkg;
  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;
  localparam int ROW_AW      = $clog2(SCREEN_H);
  localparam int COL_AW      = $clog2(SCREEN_W);
  localparam int STACK_DEPTH = 16;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int FONT_BYTES  = 80;
  localparam int FONT_AW     = $clog2(FONT_BYTES);
  localparam logic [MEM_AW-1:0] START_PC = MEM_AW'(12'h200);

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_EXEC     = 2'd1,
    CMD_READ_ROW = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_ROW, ST_F1, ST_F2, ST_F3, ST_EXEC, ST_FLAG, ST_RET,
    ST_DMEM, ST_DROWA, ST_DWA, ST_DWB, ST_BCD, ST_STRD, ST_STWR, ST_LDRD,
    ST_LDWR, ST_DONE
  } state_e;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (a < MEM_AW'(FONT_BYTES)) begin
      b = FONT[a[FONT_AW-1:0]];
    end
    return b;
  endfunction
endpackage

// File: sv/c8_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: sv/chip8_instruction_core.sv
// Top level of the instruction core: sequencer and datapath around four RAMs.
// After reset the core loads the font and zeroes program memory and takes no
// word until that is done. An instruction reads its opcode bytes and operand
// registers in ST_F1 to ST_F3, set by the single read port of program memory
// and of the register file. A sprite draw passes ST_DMEM, ST_DROWA, ST_DWA and
// ST_DWB per sprite row, BCD writes its three digits in turn, and a register
// block store or load has a read and a write state per register. A result word
// is held in an output register, so a stalled output never loses a result.
`timescale 1ns / 1ps
module chip8_instruction_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic [c8_pkg::MEM_AW-1:0]       addr_i,
  input  logic [7:0]                      data_i,
  input  logic [15:0]                     key_mask_i,
  input  logic [7:0]                      random_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [c8_pkg::MEM_AW-1:0]       pc_now_o,
  output logic [15:0]                     opcode_seen_o,
  output logic                            drew_o,
  output logic                            unknown_op_o,
  output logic                            waiting_key_o,
  output logic                            sound_on_o,
  output logic [c8_pkg::SCREEN_W-1:0]     row_pixels_o
);
  import c8_pkg::*;

  localparam logic [3:0] GRP_SYS = 4'h0, GRP_JP = 4'h1, GRP_CALL = 4'h2, GRP_SEQI = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4, GRP_SEQR = 4'h5, GRP_LDI = 4'h6, GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU = 4'h8, GRP_SNER = 4'h9, GRP_LDIX = 4'hA, GRP_JPV = 4'hB;
  localparam logic [3:0] GRP_RND = 4'hC, GRP_DRW = 4'hD, GRP_KEY = 4'hE, GRP_MISC = 4'hF;
  localparam logic [3:0] ALU_MOV = 4'h0, ALU_AND = 4'h2, ALU_XOR = 4'h3, ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5, ALU_SHL = 4'hE;
  localparam logic [11:0] SYS_CLS = 12'h0E0, SYS_RET = 12'h0EE;
  localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
  localparam logic [7:0] F_GETDT = 8'h07, F_WAITK = 8'h0A, F_SETDT = 8'h15;
  localparam logic [7:0] F_SETST = 8'h18, F_ADDI = 8'h1E, F_FONT = 8'h29;
  localparam logic [7:0] F_BCD = 8'h33, F_STORE = 8'h55, F_LOAD = 8'h65;
  localparam logic [3:0] FLAG_REG = 4'hF;
  localparam logic [7:0] HUNDRED = 8'd100;
  localparam int         FONT_STRIDE = 5;
  localparam int         WIDE_W = 2 * SCREEN_W;

  function automatic logic [3:0] top_key(input logic [15:0] k);
    logic [3:0] idx;
    idx = 4'h0;
    for (int i = 0; i < 16; i++) begin
      if (k[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  state_e state_q, state_d;

  cmd_e                cmd_q, cmd_d;
  logic [MEM_AW-1:0]   addr_q, addr_d;
  logic [15:0]         keys_q, keys_d;
  logic [7:0]          rnd_q, rnd_d;
  logic [MEM_AW-1:0]   pc_q, pc_d, idx_q, idx_d;
  logic [STACK_AW-1:0] sp_q, sp_d;
  logic [7:0]          dt_q, dt_d, st_q, st_d;
  logic [15:0]         op_q, op_d;
  logic [7:0]          vx_q, vx_d, vy_q, vy_d, byte_q, byte_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [MEM_AW-1:0]   init_q, init_d;
  logic                hit_q, hit_d, flag_q, flag_d;
  logic                drew_q, drew_d, unk_q, unk_d, wait_q, wait_d;
  logic [9:0]          drow_q, drow_d;
  logic [SCREEN_W-1:0] rowpix_q, rowpix_d;
  logic                vval_rd_q, vval_rd_d, fval_rd_q, fval_rd_d;
  logic [15:0]         vvalid_q;
  logic [SCREEN_H-1:0] fvalid_q;

  logic                out_valid_q, out_valid_d;
  logic [MEM_AW-1:0]   out_pc_q;
  logic [15:0]         out_op_q;
  logic                out_drew_q, out_unk_q, out_wait_q, out_snd_q;
  logic [SCREEN_W-1:0] out_row_q;
  logic                fire;

  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata, mem_rdata;
  logic                v_we;
  logic [3:0]          v_waddr, v_raddr;
  logic [7:0]          v_wdata, v_rdata, v_val;
  logic                f_we, f_clr;
  logic [ROW_AW-1:0]   f_waddr, f_raddr;
  logic [SCREEN_W-1:0] f_wdata, f_rdata, f_val;
  logic                s_we;
  logic [STACK_AW-1:0] s_waddr, s_raddr;
  logic [MEM_AW-1:0]   s_wdata, s_rdata;

  logic [WIDE_W-1:0]   wide;
  logic [9:0]          row0, rown;
  logic [1:0]          hund;
  logic [7:0]          rem, tens, ones;
  logic [15:0]         tens_prod;
  logic                accept;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign fire = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign v_val = vval_rd_q ? v_rdata : 8'h00;
  assign f_val = fval_rd_q ? f_rdata : '0;
  assign wide = {byte_q, {(WIDE_W-8){1'b0}}} >> vx_q[COL_AW-1:0];
  assign row0 = {2'b00, vy_q} + {6'd0, cnt_q} + {8'd0, vx_q[7:COL_AW]};
  assign rown = drow_q + 10'd1;

  assign hund = (vx_q >= 2 * HUNDRED) ? 2'd2 : ((vx_q >= HUNDRED) ? 2'd1 : 2'd0);
  assign rem = vx_q - 8'(hund * HUNDRED);
  assign tens_prod = {8'd0, rem} * 16'd205;
  assign tens = {3'd0, tens_prod[15:11]};
  assign ones = rem - 8'(tens * 8'd10);

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk_i(clk_i), .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk_i(clk_i), .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );
  c8_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_frame (
    .clk_i(clk_i), .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );
  c8_ram #(.WIDTH(MEM_AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:  if (init_q == MEM_AW'(MEM_BYTES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_EXEC:     state_d = ST_F1;
            CMD_READ_ROW: state_d = ST_ROW;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_ROW:   state_d = ST_DONE;
      ST_F1:    state_d = ST_F2;
      ST_F2:    state_d = ST_F3;
      ST_F3:    state_d = ST_EXEC;
      ST_EXEC: begin
        state_d = ST_DONE;
        case (op_q[15:12])
          GRP_SYS:  if (op_q[11:0] == SYS_RET) state_d = ST_RET;
          GRP_ALU: begin
            if (op_q[3:0] == ALU_ADD || op_q[3:0] == ALU_SUB || op_q[3:0] == ALU_SHL) begin
              state_d = ST_FLAG;
            end
          end
          GRP_DRW:  state_d = ST_DMEM;
          GRP_MISC: begin
            case (op_q[7:0])
              F_BCD:   state_d = ST_BCD;
              F_STORE: state_d = ST_STRD;
              F_LOAD:  state_d = ST_LDRD;
              default: state_d = ST_DONE;
            endcase
          end
          default:  state_d = ST_DONE;
        endcase
      end
      ST_FLAG:  state_d = ST_DONE;
      ST_RET:   state_d = ST_DONE;
      ST_DMEM:  state_d = (cnt_q == op_q[3:0]) ? ST_DONE : ST_DROWA;
      ST_DROWA: state_d = ST_DWA;
      ST_DWA:   state_d = ST_DWB;
      ST_DWB:   state_d = ST_DMEM;
      ST_BCD:   if (cnt_q == 4'd2) state_d = ST_DONE;
      ST_STRD:  state_d = ST_STWR;
      ST_STWR:  state_d = (cnt_q == op_q[11:8]) ? ST_DONE : ST_STRD;
      ST_LDRD:  state_d = ST_LDWR;
      ST_LDWR:  state_d = (cnt_q == op_q[11:8]) ? ST_DONE : ST_LDRD;
      ST_DONE:  if (fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [MEM_AW-1:0] nxt;
    logic [7:0]        dtb;
    logic              pressed;
    nxt = pc_q + MEM_AW'(2);
    dtb = dt_q;
    pressed = 1'b0;

    cmd_d = cmd_q; addr_d = addr_q; keys_d = keys_q; rnd_d = rnd_q;
    pc_d = pc_q; idx_d = idx_q; sp_d = sp_q; dt_d = dt_q; st_d = st_q;
    op_d = op_q; vx_d = vx_q; vy_d = vy_q; byte_d = byte_q; cnt_d = cnt_q;
    init_d = init_q; hit_d = hit_q; flag_d = flag_q;
    drew_d = drew_q; unk_d = unk_q; wait_d = wait_q; drow_d = drow_q;
    rowpix_d = rowpix_q; vval_rd_d = vval_rd_q; fval_rd_d = fval_rd_q;

    mem_we = 1'b0; mem_waddr = idx_q + MEM_AW'(cnt_q); mem_wdata = v_val;
    mem_raddr = idx_q + MEM_AW'(cnt_q);
    v_we = 1'b0; v_waddr = op_q[11:8]; v_wdata = 8'h00; v_raddr = cnt_q;
    f_we = 1'b0; f_clr = 1'b0; f_waddr = drow_q[ROW_AW-1:0];
    f_wdata = f_val ^ wide[WIDE_W-1:SCREEN_W]; f_raddr = row0[ROW_AW-1:0];
    s_we = 1'b0; s_waddr = sp_q; s_wdata = pc_q; s_raddr = sp_q;

    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_waddr = init_q;
        mem_wdata = font_byte(init_q);
        init_d = init_q + MEM_AW'(1);
      end
      ST_IDLE: begin
        mem_raddr = pc_q;
        f_raddr = addr_i[ROW_AW-1:0];
        fval_rd_d = fvalid_q[addr_i[ROW_AW-1:0]];
        if (accept) begin
          cmd_d = cmd_e'(cmd_i); addr_d = addr_i; keys_d = key_mask_i; rnd_d = random_byte_i;
          op_d = 16'h0000; drew_d = 1'b0; unk_d = 1'b0; wait_d = 1'b0;
          rowpix_d = '0;
          if (cmd_e'(cmd_i) == CMD_WRITE) begin
            mem_we = 1'b1;
            mem_waddr = addr_i;
            mem_wdata = data_i;
          end
        end
      end
      ST_ROW: begin
        if (addr_q < MEM_AW'(SCREEN_H)) rowpix_d = f_val;
      end
      ST_F1: begin
        op_d[15:8] = mem_rdata;
        mem_raddr = pc_q + MEM_AW'(1);
        v_raddr = mem_rdata[3:0];
        vval_rd_d = vvalid_q[mem_rdata[3:0]];
      end
      ST_F2: begin
        op_d[7:0] = mem_rdata;
        vx_d = v_val;
        v_raddr = mem_rdata[7:4];
        vval_rd_d = vvalid_q[mem_rdata[7:4]];
      end
      ST_F3: vy_d = v_val;
      ST_EXEC: begin
        cnt_d = 4'd0;
        hit_d = 1'b0;
        case (op_q[15:12])
          GRP_SYS: begin
            if (op_q[11:0] == SYS_CLS) begin
              f_clr = 1'b1;
              drew_d = 1'b1;
            end else if (op_q[11:0] == SYS_RET) begin
              sp_d = (sp_q == '0) ? STACK_AW'(STACK_DEPTH - 1) : sp_q - STACK_AW'(1);
              s_raddr = sp_d;
            end else begin
              unk_d = 1'b1;
            end
          end
          GRP_JP: nxt = op_q[11:0];
          GRP_CALL: begin
            s_we = 1'b1;
            sp_d = (sp_q == STACK_AW'(STACK_DEPTH - 1)) ? '0 : sp_q + STACK_AW'(1);
            nxt = op_q[11:0];
          end
          GRP_SEQI: if (vx_q == op_q[7:0]) nxt = pc_q + MEM_AW'(4);
          GRP_SNEI: if (vx_q != op_q[7:0]) nxt = pc_q + MEM_AW'(4);
          GRP_SEQR: if (vx_q == vy_q) nxt = pc_q + MEM_AW'(4);
          GRP_SNER: if (vx_q != vy_q) nxt = pc_q + MEM_AW'(4);
          GRP_LDI: begin
            v_we = 1'b1; v_wdata = op_q[7:0];
          end
          GRP_ADDI: begin
            v_we = 1'b1; v_wdata = vx_q + op_q[7:0];
          end
          GRP_RND: begin
            v_we = 1'b1; v_wdata = rnd_q & op_q[7:0];
          end
          GRP_ALU: begin
            v_we = 1'b1;
            case (op_q[3:0])
              ALU_MOV: v_wdata = vy_q;
              ALU_AND: v_wdata = vx_q & vy_q;
              ALU_XOR: v_wdata = vx_q ^ vy_q;
              ALU_ADD: begin
                v_wdata = vx_q + vy_q;
                flag_d = ({1'b0, vx_q} + {1'b0, vy_q}) > 9'h0FF;
              end
              ALU_SUB: begin
                v_wdata = vx_q - vy_q;
                flag_d = (vy_q <= vx_q);
              end
              ALU_SHL: begin
                v_wdata = {vx_q[6:0], 1'b0};
                flag_d = vx_q[7];
              end
              default: begin
                v_we = 1'b0;
                unk_d = 1'b1;
              end
            endcase
          end
          GRP_LDIX: idx_d = op_q[11:0];
          GRP_JPV:  unk_d = 1'b1;
          GRP_DRW:  drew_d = 1'b1;
          GRP_KEY: begin
            pressed = (vx_q < 8'd16) ? keys_q[vx_q[3:0]] : 1'b0;
            if (op_q[7:0] == KEY_DOWN) begin
              if (pressed) nxt = pc_q + MEM_AW'(4);
            end else if (op_q[7:0] == KEY_UP) begin
              if (!pressed) nxt = pc_q + MEM_AW'(4);
            end else begin
              unk_d = 1'b1;
            end
          end
          GRP_MISC: begin
            case (op_q[7:0])
              F_GETDT: begin
                v_we = 1'b1; v_wdata = dt_q;
              end
              F_WAITK: begin
                if (keys_q == 16'h0000) begin
                  wait_d = 1'b1;
                  nxt = pc_q;
                end else begin
                  v_we = 1'b1; v_wdata = {4'h0, top_key(keys_q)};
                end
              end
              F_SETDT: dtb = vx_q;
              F_SETST: st_d = vx_q;
              F_ADDI:  idx_d = idx_q + MEM_AW'(vx_q);
              F_FONT:  idx_d = MEM_AW'({4'h0, vx_q} * 12'(FONT_STRIDE));
              F_BCD, F_STORE, F_LOAD: ;
              default: unk_d = 1'b1;
            endcase
          end
          default: unk_d = 1'b1;
        endcase
        if (unk_d) nxt = pc_q;
        pc_d = nxt;
        dt_d = (dtb != 8'h00) ? dtb - 8'd1 : 8'h00;
        if (op_q[15:12] == GRP_MISC && op_q[7:0] == F_SETST) begin
          st_d = (vx_q != 8'h00) ? vx_q - 8'd1 : 8'h00;
        end else begin
          st_d = (st_q != 8'h00) ? st_q - 8'd1 : 8'h00;
        end
      end
      ST_FLAG: begin
        v_we = 1'b1; v_waddr = FLAG_REG; v_wdata = {7'd0, flag_q};
      end
      ST_RET: pc_d = s_rdata + MEM_AW'(2);
      ST_DMEM: begin
        if (cnt_q == op_q[3:0]) begin
          v_we = 1'b1; v_waddr = FLAG_REG; v_wdata = {7'd0, hit_q};
        end
      end
      ST_DROWA: begin
        byte_d = mem_rdata;
        drow_d = row0;
        fval_rd_d = fvalid_q[row0[ROW_AW-1:0]];
      end
      ST_DWA: begin
        if (drow_q < 10'(SCREEN_H)) begin
          f_we = 1'b1;
          if ((f_val & wide[WIDE_W-1:SCREEN_W]) != '0) hit_d = 1'b1;
        end
        f_raddr = rown[ROW_AW-1:0];
        fval_rd_d = fvalid_q[rown[ROW_AW-1:0]];
      end
      ST_DWB: begin
        f_waddr = rown[ROW_AW-1:0];
        f_wdata = f_val ^ wide[SCREEN_W-1:0];
        if (rown < 10'(SCREEN_H)) begin
          f_we = 1'b1;
          if ((f_val & wide[SCREEN_W-1:0]) != '0) hit_d = 1'b1;
        end
        cnt_d = cnt_q + 4'd1;
      end
      ST_BCD: begin
        mem_we = 1'b1;
        case (cnt_q)
          4'd0:    mem_wdata = {6'd0, hund};
          4'd1:    mem_wdata = tens;
          default: mem_wdata = ones;
        endcase
        cnt_d = cnt_q + 4'd1;
      end
      ST_STRD: vval_rd_d = vvalid_q[cnt_q];
      ST_STWR: begin
        mem_we = 1'b1;
        cnt_d = cnt_q + 4'd1;
      end
      ST_LDWR: begin
        v_we = 1'b1; v_waddr = cnt_q; v_wdata = mem_rdata;
        cnt_d = cnt_q + 4'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      init_q <= '0;
      pc_q <= START_PC;
      idx_q <= '0;
      sp_q <= '0;
      dt_q <= 8'h00;
      st_q <= 8'h00;
      vvalid_q <= '0;
      fvalid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q <= init_d;
      pc_q <= pc_d;
      idx_q <= idx_d;
      sp_q <= sp_d;
      dt_q <= dt_d;
      st_q <= st_d;
      if (v_we) vvalid_q[v_waddr] <= 1'b1;
      if (f_clr) begin
        fvalid_q <= '0;
      end else if (f_we) begin
        fvalid_q[f_waddr] <= 1'b1;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; addr_q <= addr_d; keys_q <= keys_d; rnd_q <= rnd_d;
    op_q <= op_d; vx_q <= vx_d; vy_q <= vy_d; byte_q <= byte_d; cnt_q <= cnt_d;
    hit_q <= hit_d; flag_q <= flag_d; drew_q <= drew_d; unk_q <= unk_d;
    wait_q <= wait_d; drow_q <= drow_d; rowpix_q <= rowpix_d;
    vval_rd_q <= vval_rd_d; fval_rd_q <= fval_rd_d;
    if (fire) begin
      out_pc_q <= pc_q;
      out_op_q <= (cmd_q == CMD_EXEC) ? op_q : 16'h0000;
      out_drew_q <= drew_q;
      out_unk_q <= unk_q;
      out_wait_q <= wait_q;
      out_snd_q <= (st_q != 8'h00);
      out_row_q <= rowpix_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pc_now_o = out_pc_q;
  assign opcode_seen_o = out_op_q;
  assign drew_o = out_drew_q;
  assign unknown_op_o = out_unk_q;
  assign waiting_key_o = out_wait_q;
  assign sound_on_o = out_snd_q;
  assign row_pixels_o = out_row_q;
endmodule

// File: sv/c8_checker.sv
// Port-level checker for the instruction core, bound to the top level.
`timescale 1ns / 1ps
`include "chip8_instruction_core_defines.svh"
module c8_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  cmd_i,
  input logic [c8_pkg::MEM_AW-1:0]   addr_i,
  input logic [7:0]                  data_i,
  input logic [15:0]                 key_mask_i,
  input logic [7:0]                  random_byte_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [c8_pkg::MEM_AW-1:0]   pc_now_o,
  input logic [15:0]                 opcode_seen_o,
  input logic                        drew_o,
  input logic                        unknown_op_o,
  input logic                        waiting_key_o,
  input logic                        sound_on_o,
  input logic [c8_pkg::SCREEN_W-1:0] row_pixels_o
);
  `C8_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "Output word dropped while stalled.")
  `C8_ASSERT(a_pc_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(pc_now_o), "Stalled output word changed.")
  `C8_ASSERT(a_unk_excl, clk_i, rst_ni, out_valid_o |-> !(unknown_op_o && (drew_o || waiting_key_o)), "Unknown opcode reported with other effects.")
  `C8_ASSERT(a_row_excl, clk_i, rst_ni, out_valid_o && (row_pixels_o != '0) |-> (opcode_seen_o == 16'h0000) && !drew_o, "Display row returned by an execute word.")
  `C8_ASSERT(a_wait_op, clk_i, rst_ni, out_valid_o && waiting_key_o |-> (opcode_seen_o[15:12] == 4'hF) && (opcode_seen_o[7:0] == 8'h0A), "Key wait reported for another opcode.")
endmodule

bind chip8_instruction_core c8_checker u_c8_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the CHIP-8 instruction core with a scoreboard class.
`timescale 1ns / 1ps
module tb;
  import c8_pkg::*;

  typedef struct packed {
    logic [MEM_AW-1:0] pc;
    logic [15:0]       op;
    logic              drew;
    logic              unk;
    logic              wait_key;
    logic              snd;
    logic [63:0]       row;
  } result_t;

  class core_scoreboard;
    logic [7:0]        mem [MEM_BYTES];
    logic [63:0]       frame [SCREEN_H];
    logic [7:0]        v [16];
    logic [MEM_AW-1:0] idx;
    logic [MEM_AW-1:0] pc;
    logic [MEM_AW-1:0] stk [STACK_DEPTH];
    logic [STACK_AW-1:0] sp;
    logic [7:0]        dly;
    logic [7:0]        snd;
    result_t           pending [$];
    int                errors;

    function void clear_state();
      for (int a = 0; a < MEM_BYTES; a++) mem[a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
      foreach (frame[r]) frame[r] = '0;
      foreach (v[r]) v[r] = '0;
      foreach (stk[r]) stk[r] = '0;
      idx = '0; pc = START_PC; sp = '0; dly = '0; snd = '0;
      errors = 0;
    endfunction

    function logic sprite(logic [7:0] x, logic [7:0] y, logic [3:0] h);
      logic hit;
      logic [7:0] bits;
      int pos;
      hit = 1'b0;
      for (int r = 0; r < h; r++) begin
        bits = mem[MEM_AW'(idx + r)];
        for (int c = 0; c < 8; c++) begin
          if (bits[7-c]) begin
            pos = x + c + (y + r) * SCREEN_W;
            if (pos < SCREEN_W * SCREEN_H) begin
              if (frame[pos / SCREEN_W][63 - pos % SCREEN_W]) hit = 1'b1;
              frame[pos / SCREEN_W][63 - pos % SCREEN_W] ^= 1'b1;
            end
          end
        end
      end
      return hit;
    endfunction

    function void note_word(cmd_e cmd, logic [11:0] addr, logic [7:0] data,
                            logic [15:0] keys, logic [7:0] rnd);
      result_t e;
      logic [15:0] op;
      logic [3:0] x, y;
      logic [7:0] nn, vx, vy;
      logic [11:0] nxt;
      logic unk, pressed;
      e = '0;
      if (cmd == CMD_WRITE) mem[addr] = data;
      else if (cmd == CMD_READ_ROW) begin
        if (addr < SCREEN_H) e.row = frame[addr];
      end else if (cmd == CMD_EXEC) begin
        op = {mem[pc], mem[MEM_AW'(pc + 1)]};
        x = op[11:8]; y = op[7:4]; nn = op[7:0];
        vx = v[x]; vy = v[y];
        nxt = pc + 12'd2;
        unk = 1'b0;
        case (op[15:12])
          4'h0: begin
            if (op[11:0] == 12'h0E0) begin
              foreach (frame[r]) frame[r] = '0;
              e.drew = 1'b1;
            end else if (op[11:0] == 12'h0EE) begin
              sp = sp - 1'b1;
              nxt = stk[sp] + 12'd2;
            end else unk = 1'b1;
          end
          4'h1: nxt = op[11:0];
          4'h2: begin stk[sp] = pc; sp = sp + 1'b1; nxt = op[11:0]; end
          4'h3: if (vx == nn) nxt += 12'd2;
          4'h4: if (vx != nn) nxt += 12'd2;
          4'h5: if (vx == vy) nxt += 12'd2;
          4'h6: v[x] = nn;
          4'h7: v[x] = vx + nn;
          4'h8: begin
            case (op[3:0])
              4'h0: v[x] = vy;
              4'h2: v[x] = vx & vy;
              4'h3: v[x] = vx ^ vy;
              4'h4: begin v[x] = vx + vy; v[15] = ({1'b0, vx} + vy) > 9'hFF; end
              4'h5: begin v[x] = vx - vy; v[15] = vy <= vx; end
              4'hE: begin v[x] = {vx[6:0], 1'b0}; v[15] = vx[7]; end
              default: unk = 1'b1;
            endcase
          end
          4'h9: if (vx != vy) nxt += 12'd2;
          4'hA: idx = op[11:0];
          4'hB: unk = 1'b1;
          4'hC: v[x] = rnd & nn;
          4'hD: begin
            v[15] = 8'h00;
            v[15] = {7'd0, sprite(vx, vy, op[3:0])};
            e.drew = 1'b1;
          end
          4'hE: begin
            pressed = (vx < 16) ? keys[vx[3:0]] : 1'b0;
            if (nn == 8'h9E) begin if (pressed) nxt += 12'd2; end
            else if (nn == 8'hA1) begin if (!pressed) nxt += 12'd2; end
            else unk = 1'b1;
          end
          default: begin
            case (nn)
              8'h07: v[x] = dly;
              8'h0A: begin
                if (keys == 0) begin e.wait_key = 1'b1; nxt = pc; end
                else for (int i = 0; i < 16; i++) if (keys[i]) v[x] = 8'(i);
              end
              8'h15: dly = vx;
              8'h18: snd = vx;
              8'h1E: idx = idx + vx;
              8'h29: idx = 12'(vx * 5);
              8'h33: begin
                mem[idx] = vx / 100;
                mem[MEM_AW'(idx + 1)] = (vx / 10) % 10;
                mem[MEM_AW'(idx + 2)] = vx % 10;
              end
              8'h55: for (int i = 0; i <= x; i++) mem[MEM_AW'(idx + i)] = v[i];
              8'h65: for (int i = 0; i <= x; i++) v[i] = mem[MEM_AW'(idx + i)];
              default: unk = 1'b1;
            endcase
          end
        endcase
        if (unk) nxt = pc;
        pc = nxt;
        if (dly != 0) dly--;
        if (snd != 0) snd--;
        e.op = op;
        e.unk = unk;
      end
      e.pc = pc;
      e.snd = snd != 0;
      pending.push_back(e);
    endfunction

    function void check_word(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word pc=%h", $time, got.pc);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.pc !== w.pc) begin
        $display("%0t: pc_now expected %h actual %h", $time, w.pc, got.pc); errors++;
      end
      if (got.op !== w.op) begin
        $display("%0t: opcode_seen expected %h actual %h", $time, w.op, got.op); errors++;
      end
      if (got.drew !== w.drew) begin
        $display("%0t: drew expected %b actual %b", $time, w.drew, got.drew); errors++;
      end
      if (got.unk !== w.unk) begin
        $display("%0t: unknown_op expected %b actual %b", $time, w.unk, got.unk); errors++;
      end
      if (got.wait_key !== w.wait_key) begin
        $display("%0t: waiting_key expected %b actual %b", $time, w.wait_key, got.wait_key);
        errors++;
      end
      if (got.snd !== w.snd) begin
        $display("%0t: sound_on expected %b actual %b", $time, w.snd, got.snd); errors++;
      end
      if (got.row !== w.row) begin
        $display("%0t: row_pixels expected %h actual %h", $time, w.row, got.row); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = '0;
  logic [MEM_AW-1:0] addr_i = '0;
  logic [7:0] data_i = '0;
  logic [15:0] key_mask_i = '0;
  logic [7:0] random_byte_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [MEM_AW-1:0] pc_now_o;
  logic [15:0] opcode_seen_o;
  logic drew_o, unknown_op_o, waiting_key_o, sound_on_o;
  logic [SCREEN_W-1:0] row_pixels_o;

  core_scoreboard sb;
  int idle_cycles = 0;
  int exec_depth = 0;
  logic [MEM_AW-1:0] prog_ptr;

  chip8_instruction_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word({pc_now_o, opcode_seen_o, drew_o, unknown_op_o, waiting_key_o,
                     sound_on_o, row_pixels_o});
  end

  int stall_left = 0;
  logic stall_quiet = 1'b0;
  always @(posedge clk_i) begin
    if (stall_quiet) out_stall_i <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_left <= gap_len();
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(cmd_e cmd, logic [11:0] addr, logic [7:0] data,
                           logic [15:0] keys, logic [7:0] rnd, bit quiet_gap);
    int g;
    g = quiet_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd; addr_i <= addr; data_i <= data;
    key_mask_i <= keys; random_byte_i <= rnd;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(cmd, addr, data, keys, rnd);
  endtask

  task automatic run_op(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
    send_word(CMD_WRITE, sb.pc, op[15:8], 16'($urandom), 8'($urandom), 0);
    send_word(CMD_WRITE, sb.pc + 12'd1, op[7:0], 16'($urandom), 8'($urandom), 0);
    send_word(CMD_EXEC, 12'($urandom), 8'($urandom), keys, rnd, 0);
  endtask

  function automatic logic [15:0] pick_op();
    logic [3:0] x, y;
    logic [7:0] nn;
    x = 4'($urandom); y = 4'($urandom); nn = 8'($urandom);
    case ($urandom_range(0, 27))
      0: return 16'h00E0;
      1: return (exec_depth > 0) ? 16'h00EE : 16'h6000 | {x, nn};
      2: return {4'h1, 12'($urandom)};
      3: return (exec_depth < 12) ? {4'h2, 12'($urandom)} : 16'h00E0;
      4: return {4'h3, x, nn};
      5: return {4'h4, x, nn};
      6: return {4'h5, x, y, 4'($urandom)};
      7, 8: return {4'h6, x, nn};
      9: return {4'h7, x, nn};
      10: begin
        case ($urandom_range(0, 6))
          0: return {4'h8, x, y, 4'h0};
          1: return {4'h8, x, y, 4'h2};
          2: return {4'h8, x, y, 4'h3};
          3: return {4'h8, x, y, 4'h4};
          4: return {4'h8, x, y, 4'h5};
          5: return {4'h8, x, y, 4'hE};
          default: return {4'h8, x, y, 4'($urandom)};
        endcase
      end
      11: return {4'h9, x, y, 4'($urandom)};
      12: return {4'hA, 12'($urandom)};
      13: return {4'hB, 12'($urandom)};
      14: return {4'hC, x, nn};
      15, 16: return {4'hD, x, y, 4'($urandom)};
      17: return {4'hE, x, 8'h9E};
      18: return {4'hE, x, 8'hA1};
      19: return {4'hE, x, nn};
      20: return {4'hF, x, 8'h07};
      21: return {4'hF, x, 8'h0A};
      22: return {4'hF, x, 8'h15};
      23: return {4'hF, x, 8'h18};
      24: return {4'hF, x, 8'h1E};
      25: return {4'hF, x, 8'h29};
      26: return {4'hF, x, ($urandom_range(0, 1) != 0) ? 8'h33 : 8'h55};
      default: return {4'hF, x, ($urandom_range(0, 3) != 0) ? 8'h65 : nn};
    endcase
  endfunction

  task automatic exec_tracked(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
    logic [STACK_AW-1:0] before_sp;
    before_sp = sb.sp;
    run_op(op, keys, rnd);
    if (sb.sp == before_sp + 1'b1) exec_depth++;
    else if (sb.sp == before_sp - 1'b1) exec_depth--;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    stall_quiet = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    stall_quiet = 1'b0;
  endtask

  logic [15:0] kmask;
  int r;
  initial begin
    sb = new();
    sb.clear_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_op(16'h60FF, 16'h0000, 8'h00);
    run_op(16'h6101, 16'h0000, 8'h00);
    run_op(16'h8014, 16'h0000, 8'h00);
    run_op(16'h8F15, 16'h0000, 8'h00);
    run_op(16'h8F0E, 16'h0000, 8'h00);
    run_op(16'h633F, 16'h0000, 8'h00);
    run_op(16'h641F, 16'h0000, 8'h00);
    run_op(16'hA000, 16'h0000, 8'h00);
    run_op(16'hD34F, 16'h0000, 8'h00);
    run_op(16'hD34F, 16'h0000, 8'h00);
    run_op(16'hF50A, 16'h0000, 8'h00);
    run_op(16'hF50A, 16'h8001, 8'h00);
    run_op(16'h65FF, 16'h0000, 8'h00);
    run_op(16'hE59E, 16'hFFFF, 8'h00);
    run_op(16'hE5A1, 16'hFFFF, 8'h00);
    run_op(16'h5016, 16'h0000, 8'h00);
    run_op(16'hCAF0, 16'h0000, 8'hFF);
    run_op(16'hF518, 16'h0000, 8'h00);
    run_op(16'hFFFF, 16'h0000, 8'h00);
    send_word(CMD_NONE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 0);
    send_word(CMD_READ_ROW, 12'd31, 8'h00, 16'h0000, 8'h00, 0);
    send_word(CMD_READ_ROW, 12'hFFF, 8'h00, 16'h0000, 8'h00, 0);
    run_op(16'h1FFE, 16'h0000, 8'h00);
    run_op(16'h00E0, 16'h0000, 8'h00);
    wait_drained();

    for (int n = 0; n < 500; n++) begin
      r = $urandom_range(0, 19);
      if (n == 250) wait_drained();
      if (r < 14) begin
        kmask = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        exec_tracked(pick_op(), kmask, 8'($urandom));
      end else if (r < 16) begin
        send_word(CMD_READ_ROW, ($urandom_range(0, 7) == 0) ? 12'($urandom)
                  : 12'($urandom_range(0, 31)), 8'($urandom), 16'($urandom),
                  8'($urandom), 0);
      end else if (r < 18) begin
        prog_ptr = MEM_AW'($urandom);
        send_word(CMD_WRITE, prog_ptr, 8'($urandom), 16'($urandom), 8'($urandom), 0);
      end else if (r < 19) begin
        if (exec_depth <= 0 &&
            {sb.mem[sb.pc], sb.mem[MEM_AW'(sb.pc + 1)]} == 16'h00EE) begin
          send_word(CMD_READ_ROW, 12'($urandom_range(0, 31)), 8'($urandom),
                    16'($urandom), 8'($urandom), 0);
        end else begin
          send_word(CMD_EXEC, 12'($urandom), 8'($urandom), 16'($urandom),
                    8'($urandom), 0);
          if (sb.pending[$].op[15:12] == 4'h2) exec_depth++;
          if (sb.pending[$].op == 16'h00EE) exec_depth--;
        end
      end else begin
        send_word(CMD_NONE, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 1);
      end
    end

    in_valid_i <= 1'b0;
    stall_quiet = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/c8_pkg.sv
sv/c8_ram.sv
sv/chip8_instruction_core.sv
sv/c8_checker.sv
tb/tb.sv
